// File: rtl/binary_trie_longest_prefix_match_top_defines.svh
// Assertion macros for the binary trie longest-prefix-match block.
// Used by binary_trie_longest_prefix_match_top; expects clock and reset in scope.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_TOP_DEFINES_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTLPM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTLPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/btlpm_pkg.sv
// Shared types and constants for the binary trie longest-prefix-match block.
// No dependencies; imported by the top level.
package btlpm_pkg;

   localparam int NODE_CAPACITY_DEF = 4096;

   localparam logic [7:0] IPV4_BITS = 8'd32;
   localparam logic [7:0] IPV6_BITS = 8'd128;

   localparam int REQ_TDATA_W = 192;
   localparam int RSP_TDATA_W = 72;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Record held in a trie node.
   typedef struct packed {
      logic [7:0]  len;
      logic [7:0]  lic;
      logic [7:0]  conf;
      logic [7:0]  tier;
      logic [31:0] app;
   } rec_type;

   // Result item, status in bit 0.
   typedef struct packed {
      logic [7:0]  len;
      logic [7:0]  lic;
      logic [7:0]  conf;
      logic [7:0]  tier;
      logic [31:0] app;
      logic        hit;
      logic        status;
   } rsp_type;

   localparam int RSP_PAD_W = RSP_TDATA_W - $bits(rsp_type);

endpackage

// File: rtl/btlpm_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module btlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wr_data;
      end
      if (re) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/binary_trie_longest_prefix_match_top.sv
// Binary trie longest-prefix match: walk controller, node store and result register.
// Depends on btlpm_pkg, btlpm_ram and binary_trie_longest_prefix_match_top_defines.svh.
//
// Use:
//   req_* carries one command per transfer: req_tuser selects insert (0) or
//   lookup (1); req_tdata holds address, prefix length and the record.
//   rsp_* returns exactly one result per command: status, hit and the
//   record of the longest matching prefix.
//   csr_we/csr_wdata set ipv6_mode; write it only while the block is idle.
// Sequencing:
//   One command at a time. A command passes from its transfer to the result
//   register through accept, one walk step per trie level visited (root
//   included) and the result load. The bound is the single node-memory
//   port, used once per level. An over-long insert skips the walk.
// Reset: synchronous, active high. After reset the INIT state clears the root
//   node; req_tready rises in the cycle after it. One node, ipv6_mode 0.
// Stall: the result sits in an output register; a new command is accepted
//   while it waits, and a finished command holds in its last state until it frees.
`include "binary_trie_longest_prefix_match_top_defines.svh"

module binary_trie_longest_prefix_match_top #(
   parameter int NODE_CAPACITY = btlpm_pkg::NODE_CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata, low bit up: addr_hi[63:0], addr_lo[127:64], plen[135:128],
   // app_id[167:136], tier[175:168], confidence[183:176], lic_tier[191:184]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [btlpm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: cmd
   input  logic                                req_tuser,
   // rsp_tdata, low bit up: status[0], hit[1], match_app[33:2], match_tier[41:34],
   // match_confidence[49:42], match_license[57:50], match_len[65:58], zeros
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [btlpm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                                csr_we,
   input  logic                                csr_wdata
);

   import btlpm_pkg::*;

   localparam int IDX_W = $clog2(NODE_CAPACITY);
   localparam int CNT_W = $clog2(NODE_CAPACITY + 1);

   // One memory word per trie node.
   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             valid;
      rec_type          rec;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef enum logic [3:0] {
      ST_INIT = 4'b0001,
      ST_IDLE = 4'b0010,
      ST_WALK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type        st_ff, st_in;
   logic             mode_ff, mode_in;
   logic             cmd_ff, cmd_in;
   logic [7:0]       plen_ff, plen_in;
   logic [7:0]       limit_ff, limit_in;
   rec_type          rec_ff, rec_in;
   logic [127:0]     addr_sh_ff, addr_sh_in;
   logic [7:0]       depth_ff, depth_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   node_type         word_ff, word_in;
   logic             fresh_ff, fresh_in;   // current word comes from the RAM port
   logic             dirty_ff, dirty_in;   // current node just allocated, not yet written
   logic [CNT_W-1:0] nodes_used_ff, nodes_used_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             ram_we, ram_re;
   logic [IDX_W-1:0] ram_addr;
   logic [NODE_W-1:0] ram_wdata, ram_rdata;

   node_type         word;
   node_type         wr_word;
   logic [IDX_W-1:0] child;
   logic             bit_v;
   logic             at_end;
   logic             out_free;
   logic [7:0]       req_limit;
   logic             req_xfer;

   btlpm_ram #(
      .WIDTH(NODE_W),
      .DEPTH(NODE_CAPACITY)
   ) u_nodes (
      .clock   (clock),
      .we      (ram_we),
      .re      (ram_re),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign word     = fresh_ff ? node_type'(ram_rdata) : word_ff;
   assign bit_v    = addr_sh_ff[127];
   assign child    = bit_v ? word.right : word.left;
   assign at_end   = (cmd_ff == CMD_INSERT) ? (depth_ff == plen_ff) : (depth_ff == limit_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (st_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_limit  = mode_ff ? IPV6_BITS : IPV4_BITS;

   always_comb begin
      st_in         = st_ff;
      mode_in       = csr_we ? csr_wdata : mode_ff;
      cmd_in        = cmd_ff;
      plen_in       = plen_ff;
      limit_in      = limit_ff;
      rec_in        = rec_ff;
      addr_sh_in    = addr_sh_ff;
      depth_in      = depth_ff;
      cur_in        = cur_ff;
      word_in       = word;
      fresh_in      = 1'b0;
      dirty_in      = dirty_ff;
      nodes_used_in = nodes_used_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_addr      = cur_ff;
      wr_word       = word;

      unique case (st_ff)
         ST_INIT: begin
            // clear the root node
            ram_we   = 1'b1;
            ram_addr = '0;
            wr_word  = '0;
            st_in    = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in      = req_tuser;
               plen_in     = req_tdata[135:128];
               limit_in    = req_limit;
               rec_in.app  = req_tdata[167:136];
               rec_in.tier = req_tdata[175:168];
               rec_in.conf = req_tdata[183:176];
               rec_in.lic  = req_tdata[191:184];
               rec_in.len  = req_tdata[135:128];
               addr_sh_in  = {req_tdata[63:0], req_tdata[127:64]};
               depth_in    = '0;
               cur_in      = '0;
               dirty_in    = 1'b0;
               res_in      = '0;
               if (req_tuser == CMD_INSERT && req_tdata[135:128] > req_limit) begin
                  res_in.status = 1'b1;
                  st_in         = ST_DONE;
               end else begin
                  ram_re   = 1'b1;
                  ram_addr = '0;
                  fresh_in = 1'b1;
                  st_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (cmd_ff == CMD_LOOKUP) begin
               if (word.valid) begin
                  res_in.hit  = 1'b1;
                  res_in.app  = word.rec.app;
                  res_in.tier = word.rec.tier;
                  res_in.conf = word.rec.conf;
                  res_in.lic  = word.rec.lic;
                  res_in.len  = word.rec.len;
               end
               if (at_end || child == '0) begin
                  st_in = ST_DONE;
               end else begin
                  ram_re     = 1'b1;
                  ram_addr   = child;
                  cur_in     = child;
                  fresh_in   = 1'b1;
                  depth_in   = depth_ff + 8'd1;
                  addr_sh_in = {addr_sh_ff[126:0], 1'b0};
               end
            end else if (at_end) begin
               // store on empty node or strictly higher confidence
               if (!word.valid || rec_ff.conf > word.rec.conf) begin
                  wr_word.valid = 1'b1;
                  wr_word.rec   = rec_ff;
                  ram_we        = 1'b1;
               end
               st_in = ST_DONE;
            end else if (child != '0) begin
               ram_re     = 1'b1;
               ram_addr   = child;
               cur_in     = child;
               fresh_in   = 1'b1;
               depth_in   = depth_ff + 8'd1;
               addr_sh_in = {addr_sh_ff[126:0], 1'b0};
            end else if (nodes_used_ff >= CNT_W'(NODE_CAPACITY)) begin
               // store full: keep the path built so far, no record
               ram_we        = dirty_ff;
               res_in.status = 1'b1;
               st_in         = ST_DONE;
            end else begin
               // link a fresh node; its own word is written when we leave it
               if (bit_v) begin
                  wr_word.right = nodes_used_ff[IDX_W-1:0];
               end else begin
                  wr_word.left  = nodes_used_ff[IDX_W-1:0];
               end
               ram_we        = 1'b1;
               word_in       = '0;
               dirty_in      = 1'b1;
               cur_in        = nodes_used_ff[IDX_W-1:0];
               nodes_used_in = nodes_used_ff + CNT_W'(1);
               depth_in      = depth_ff + 8'd1;
               addr_sh_in    = {addr_sh_ff[126:0], 1'b0};
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_INIT;
         end
      endcase

      ram_wdata = NODE_W'(wr_word);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_INIT;
         mode_ff       <= 1'b0;
         nodes_used_ff <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
         fresh_ff      <= 1'b0;
         dirty_ff      <= 1'b0;
      end else begin
         st_ff         <= st_in;
         mode_ff       <= mode_in;
         nodes_used_ff <= nodes_used_in;
         rsp_valid_ff  <= rsp_valid_in;
         fresh_ff      <= fresh_in;
         dirty_ff      <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      plen_ff     <= plen_in;
      limit_ff    <= limit_in;
      rec_ff      <= rec_in;
      addr_sh_ff  <= addr_sh_in;
      depth_ff    <= depth_in;
      cur_ff      <= cur_in;
      word_ff     <= word_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

   // node count never runs past the store
   `BTLPM_ASSERT_IMPL(a_nodes_bound, 1'b1, nodes_used_ff <= CNT_W'(NODE_CAPACITY),
      "node count beyond capacity")
   // one node-memory access per cycle
   `BTLPM_ASSERT_IMPL(a_one_access, ram_we, !ram_re, "read and write in one cycle")
   // walk never goes deeper than an IPv6 address
   `BTLPM_ASSERT_IMPL(a_depth_bound, st_ff == ST_WALK, depth_ff <= IPV6_BITS,
      "walk depth out of range")
   // a finished command reaches the output register when it is free
   `BTLPM_ASSERT_NEXT(a_result_load, st_ff == ST_DONE && out_free,
      rsp_valid_ff && st_ff == ST_IDLE, "result not loaded")

endmodule

// File: test/binary_trie_longest_prefix_match_top_tb.sv
// Self-checking bench for binary_trie_longest_prefix_match_top: a shadow trie predicts every
// result of a directed and a random command stream over IPv4 and IPv6 modes.
// Depends on btlpm_pkg and the RTL of the block; reads no files.
module binary_trie_longest_prefix_match_top_tb;
   import btlpm_pkg::*;

   localparam int          NODES        = NODE_CAPACITY_DEF;
   localparam int          POOL_N       = 6;
   localparam int unsigned LIMIT_CYCLES = 1_200_000;

   // One command as the bench sees it; packed to req_tdata low field first.
   typedef struct packed {
      logic        cmd;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [7:0]  plen;
      logic [31:0] app;
      logic [7:0]  tier;
      logic [7:0]  conf;
      logic [7:0]  lic;
   } lpm_cmd_type;

   // Shadow copy of the trie. Each accepted command is walked here in the same
   // order as in the block, and its result is queued for the response checker.
   class trie_shadow_type;
      logic [11:0] left_link [NODES];
      logic [11:0] right_link [NODES];
      bit          has_route [NODES];
      rec_type     route_rec [NODES];
      int          nodes_taken;
      bit          ipv6;
      int          errors;
      rsp_type     expected_matches [$];

      function new();
         for (int n = 0; n < NODES; n++) begin
            left_link[n]  = '0;
            right_link[n] = '0;
            has_route[n]  = 1'b0;
            route_rec[n]  = '0;
         end
         nodes_taken = 1;
         ipv6        = 1'b0;
         errors      = 0;
      endfunction

      // Walk order is MSB first: addr_hi[63] is level 0, addr_lo[0] is level 127.
      function bit addr_bit(input lpm_cmd_type c, input int pos);
         return (pos < 64) ? c.hi[63 - pos] : c.lo[127 - pos];
      endfunction

      function void predict_match(input lpm_cmd_type c);
         rsp_type     res;
         logic [11:0] cur;
         logic [11:0] nxt;
         logic [11:0] best;
         bit          dir;
         bit          full;
         bit          found;
         int          walk;
         res  = '0;
         cur  = '0;
         full = 1'b0;
         walk = ipv6 ? 128 : 32;
         if (c.cmd == CMD_INSERT) begin
            if (int'(c.plen) > walk) begin
               res.status = 1'b1;          // too long for the mode, nothing touched
            end else begin
               for (int i = 0; i < int'(c.plen) && !full; i++) begin
                  dir = addr_bit(c, i);
                  nxt = dir ? right_link[cur] : left_link[cur];
                  if (nxt == '0) begin
                     if (nodes_taken >= NODES) begin
                        full = 1'b1;       // nodes taken so far stay linked
                     end else begin
                        nxt = 12'(nodes_taken);
                        nodes_taken++;
                        left_link[nxt]  = '0;
                        right_link[nxt] = '0;
                        has_route[nxt]  = 1'b0;
                        if (dir) right_link[cur] = nxt;
                        else left_link[cur] = nxt;
                     end
                  end
                  if (!full) cur = nxt;
               end
               if (full) begin
                  res.status = 1'b1;
               end else if (!has_route[cur] || c.conf > route_rec[cur].conf) begin
                  has_route[cur] = 1'b1;
                  route_rec[cur] = {c.plen, c.lic, c.conf, c.tier, c.app};
               end
            end
         end else begin
            found = has_route[0];
            best  = '0;
            for (int i = 0; i < walk; i++) begin
               nxt = addr_bit(c, i) ? right_link[cur] : left_link[cur];
               if (nxt == '0) break;
               cur = nxt;
               if (has_route[cur]) begin
                  found = 1'b1;
                  best  = cur;
               end
            end
            if (found) begin
               res.hit  = 1'b1;
               res.app  = route_rec[best].app;
               res.tier = route_rec[best].tier;
               res.conf = route_rec[best].conf;
               res.lic  = route_rec[best].lic;
               res.len  = route_rec[best].len;
            end
         end
         expected_matches.push_back(res);
      endfunction

      function void match_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(input logic [RSP_TDATA_W-1:0] word);
         rsp_type got;
         rsp_type want;
         got = word[$bits(rsp_type)-1:0];
         if (expected_matches.size() == 0) begin
            $error("unexpected result transfer %0h", word);
            errors++;
         end else begin
            want = expected_matches.pop_front();
            match_field("status", 32'(want.status), 32'(got.status));
            match_field("hit", 32'(want.hit), 32'(got.hit));
            match_field("match_app", want.app, got.app);
            match_field("match_tier", 32'(want.tier), 32'(got.tier));
            match_field("match_confidence", 32'(want.conf), 32'(got.conf));
            match_field("match_license", 32'(want.lic), 32'(got.lic));
            match_field("match_len", 32'(want.len), 32'(got.len));
            match_field("padding", 32'(0), 32'(word[RSP_TDATA_W-1 -: RSP_PAD_W]));
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic                   csr_wdata  = 1'b0;

   trie_shadow_type shadow = new();
   logic [127:0] route_pool [POOL_N];   // seed addresses, random commands cluster around them
   int           send_run  = 0;
   bit           send_calm = 1'b0;
   int unsigned  cycle_count = 0;

   binary_trie_longest_prefix_match_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: stops the run at LIMIT_CYCLES and reports errors.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("binary_trie_longest_prefix_match_top_tb: done, errors");
         $finish;
      end
   end

   // Idle cycles before the next transfer: runs of 10..60 transfers either
   // draw a random gap each or none at all, so back-to-back streams occur too.
   function automatic int pick_wait(ref int run_left, ref bit calm);
      if (run_left == 0) begin
         run_left = $urandom_range(10, 60);
         calm     = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic lpm_cmd_type cmd_item(input logic cmd, input logic [63:0] hi,
                                            input logic [63:0] lo, input logic [7:0] plen,
                                            input logic [31:0] app, input logic [7:0] tier,
                                            input logic [7:0] conf, input logic [7:0] lic);
      lpm_cmd_type c;
      c = {cmd, hi, lo, plen, app, tier, conf, lic};
      return c;
   endfunction

   // Random command: keeps the first k walk bits of a pool address and
   // randomizes the rest. Inserts mostly branch off a few levels above their
   // end, so the trie grows deep but slowly; lookups mostly follow stored
   // paths. A few over-long inserts and fully random addresses are noise.
   // In the filling phase many full-depth inserts start near the root and
   // exhaust the node store.
   function automatic lpm_cmd_type make_command(input bit fill);
      lpm_cmd_type  c;
      int           walk;
      int           pick;
      int           k;
      logic [127:0] a;
      logic [127:0] mask;
      walk   = shadow.ipv6 ? 128 : 32;
      pick   = $urandom_range(0, 99);
      a      = route_pool[$urandom_range(0, POOL_N - 1)];
      c.cmd  = (pick < 45) ? CMD_INSERT : CMD_LOOKUP;
      c.plen = 8'($urandom_range(0, 255));
      if (c.cmd == CMD_INSERT) begin
         if (fill && pick < 30) begin
            c.plen = 8'd128;
            k      = $urandom_range(0, 16);
         end else if (pick < 5) begin
            k = 0;                          // raw length, mostly over-long
         end else begin
            if (shadow.ipv6 && $urandom_range(0, 2) == 0)
               c.plen = 8'($urandom_range(64, 128));
            else c.plen = 8'($urandom_range(0, shadow.ipv6 ? 64 : 32));
            if (pick < 10) k = int'($urandom_range(0, c.plen));
            else k = int'(c.plen) - int'($urandom_range(0, 4));
            if (k < 0) k = 0;
         end
      end else begin
         if (pick < 90) k = walk - int'($urandom_range(0, 8));
         else k = 0;
      end
      mask = {128{1'b1}} >> k;
      a    = (a & ~mask) | ({$urandom(), $urandom(), $urandom(), $urandom()} & mask);
      c.hi = a[127:64];
      c.lo = a[63:0];
      c.app  = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom();
      c.tier = 8'($urandom_range(0, 255));
      c.lic  = 8'($urandom_range(0, 255));
      c.conf = 8'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
      return c;
   endfunction

   // One request transfer. tvalid is only lowered when a gap follows, so a
   // back-to-back item never sees two assignments in one step.
   task automatic send_command(input lpm_cmd_type c);
      int gap;
      gap = pick_wait(send_run, send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.cmd;
      req_tdata  <= {c.lic, c.conf, c.tier, c.app, c.plen, c.lo, c.hi};
      do @(posedge clock); while (req_tready !== 1'b1);
      shadow.predict_match(c);
   endtask

   task automatic run_random(input int count, input bit fill);
      for (int p = 0; p < POOL_N; p++)
         route_pool[p] = {$urandom(), $urandom(), $urandom(), $urandom()};
      repeat (count) send_command(make_command(fill));
   endtask

   // Mode writes only with the block drained; every command returns a
   // result, so an empty queue plus a short pause means idle.
   task automatic set_ipv6_mode(input bit v6);
      req_tvalid <= 1'b0;
      while (shadow.expected_matches.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v6;
      @(posedge clock);
      csr_we      <= 1'b0;
      shadow.ipv6 = v6;
   endtask

   // Response side: random stalls, plus one long hold-off after 300 results
   // while the sender keeps offering, so the block backs up into req_tready.
   initial begin : drain
      int waitc;
      int run_left;
      int got;
      bit calm;
      run_left = 0;
      got      = 0;
      calm     = 1'b0;
      forever begin
         waitc = pick_wait(run_left, calm);
         if (got == 300) waitc = 600;
         if (waitc > 0) begin
            rsp_tready <= 1'b0;
            repeat (waitc) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         shadow.check_result(rsp_tdata);
         got++;
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // IPv4, directed
      set_ipv6_mode(1'b0);
      send_command(cmd_item(CMD_LOOKUP, '0, '0, 8'd0, '0, '0, '0, '0));     // empty trie
      send_command(cmd_item(CMD_INSERT, '0, '0, 8'd0, 32'hFFFF_FFFF, 8'd1, 8'd10, 8'd2));
      send_command(cmd_item(CMD_LOOKUP, 64'h1234_5678_0000_0000, '0, 8'd0, '0, '0, '0, '0));
      send_command(cmd_item(CMD_INSERT, 64'hFFFF_FFFF_0000_0000, '0, 8'd32, 32'h0,
                            8'hFF, 8'd0, 8'hFF));
      send_command(cmd_item(CMD_LOOKUP, 64'hFFFF_FFFF_0000_0000, '0, 8'd0, '0, '0, '0, '0));
      // equal confidence keeps, higher replaces, lower keeps
      send_command(cmd_item(CMD_INSERT, 64'hFFFF_FFFF_0000_0000, '0, 8'd32, 32'hA5A5,
                            8'd3, 8'd0, 8'd3));
      send_command(cmd_item(CMD_INSERT, 64'hFFFF_FFFF_0000_0000, '0, 8'd32, 32'h5A5A,
                            8'd4, 8'd255, 8'd4));
      send_command(cmd_item(CMD_INSERT, 64'hFFFF_FFFF_0000_0000, '0, 8'd32, 32'h1111,
                            8'd5, 8'd200, 8'd5));
      send_command(cmd_item(CMD_LOOKUP, '1, '1, 8'd0, '0, '0, '0, '0));
      // over-long prefixes for IPv4
      send_command(cmd_item(CMD_INSERT, '1, '1, 8'd33, 32'h22, 8'd6, 8'd6, 8'd6));
      send_command(cmd_item(CMD_INSERT, '1, '1, 8'd128, 32'h23, 8'd6, 8'd6, 8'd6));
      send_command(cmd_item(CMD_INSERT, '1, '1, 8'd255, 32'h24, 8'd6, 8'd6, 8'd6));
      send_command(cmd_item(CMD_INSERT, 64'h8000_0000_0000_0000, '0, 8'd1, 32'h7,
                            8'd7, 8'd7, 8'd7));
      send_command(cmd_item(CMD_LOOKUP, 64'hC000_0000_0000_0000, '0, 8'd0, '0, '0, '0, '0));
      send_command(cmd_item(CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0, 8'd0, '0, '0, '0, '0));
      send_command(cmd_item(CMD_LOOKUP, '0, '1, 8'd0, '0, '0, '0, '0));     // addr_lo ignored
      // record on an interior node of an existing path
      send_command(cmd_item(CMD_INSERT, 64'hFFFF_FFFE_0000_0000, '0, 8'd31, 32'h31,
                            8'd8, 8'd1, 8'd8));
      send_command(cmd_item(CMD_LOOKUP, 64'hFFFF_FFFE_0000_0000, '0, 8'd0, '0, '0, '0, '0));
      run_random(620, 1'b0);

      // IPv6, directed then random
      set_ipv6_mode(1'b1);
      send_command(cmd_item(CMD_INSERT, '1, '1, 8'd128, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
      send_command(cmd_item(CMD_LOOKUP, '1, '1, 8'd0, '0, '0, '0, '0));
      send_command(cmd_item(CMD_INSERT, '1, '1, 8'd129, 32'h9, 8'd9, 8'd9, 8'd9));
      send_command(cmd_item(CMD_LOOKUP, '1, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0, '0, '0, '0, '0));
      send_command(cmd_item(CMD_INSERT, '0, 64'h1, 8'd128, 32'h10, 8'd10, 8'd3, 8'd10));
      send_command(cmd_item(CMD_LOOKUP, '0, 64'h1, 8'd0, '0, '0, '0, '0));
      run_random(700, 1'b0);

      // back to IPv4: trie kept, deep IPv6 routes out of reach
      set_ipv6_mode(1'b0);
      send_command(cmd_item(CMD_LOOKUP, '1, '1, 8'd0, '0, '0, '0, '0));
      run_random(160, 1'b0);

      // IPv6 again, filling the node store until inserts are refused
      set_ipv6_mode(1'b1);
      run_random(200, 1'b1);

      req_tvalid <= 1'b0;
      while (shadow.expected_matches.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);   // any stray result shows up in the drain
      if (shadow.errors == 0)
         $display("binary_trie_longest_prefix_match_top_tb: done, clean");
      else
         $display("binary_trie_longest_prefix_match_top_tb: done, errors");
      $finish;
   end

endmodule
